// ===== src/radix_string_to_integer_parser_top_macros.svh =====
// Assertion macros for the radix string-to-integer parser.
// Used by the port checker; no other dependencies.
`ifndef RADIX_STRING_TO_INTEGER_PARSER_TOP_MACROS_SVH
`define RADIX_STRING_TO_INTEGER_PARSER_TOP_MACROS_SVH

// Clocked assertion, disabled while reset is asserted (active low)
`define RSIP_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("rsip assertion failed");

// Clocked assertion that also holds during reset
`define RSIP_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("rsip assertion failed");

`endif

// ===== src/rsip_pkg.sv =====
// Shared types and constants of the radix string-to-integer parser.
// No dependencies.
package rsip_pkg;

  // Field and register widths
  localparam int unsigned SYM_W   = 8;
  localparam int unsigned NUM_SYM = 16;
  localparam int unsigned CNT_W   = 5;
  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned DATA_W  = 64;
  localparam int unsigned ADDR_W  = 5;

  // Register indexes (byte address is 8 * index)
  localparam logic [1:0] REG_DIGIT_COUNT  = 2'd0;
  localparam logic [1:0] REG_SYMBOLS_LOW  = 2'd1;
  localparam logic [1:0] REG_SYMBOLS_HIGH = 2'd2;

  // Character codes
  localparam logic [SYM_W-1:0] CH_TAB   = 8'd9;
  localparam logic [SYM_W-1:0] CH_CR    = 8'd13;
  localparam logic [SYM_W-1:0] CH_SPACE = 8'h20;
  localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [SYM_W-1:0] CH_NUL   = 8'h00;

  // Alphabet lookup results handed to the parse logic
  typedef struct packed {
    logic               hit;      // character is an alphabet symbol
    logic [DIGIT_W-1:0] digit;    // its lowest position
    logic [CNT_W-1:0]   radix;    // symbol count clamped to the maximum
    logic               ok;       // alphabet passes all checks
  } rsip_alpha_t;

endpackage

// ===== src/radix_string_to_integer_parser_top.sv =====
// Radix string-to-integer parser: one character per item, configurable alphabet.
// Depends on rsip_pkg and rsip_alphabet.
//
//   channel   direction  handshake               payload
//   in        sink       in_valid_i / in_stall_o  char_code_i, last_i
//   out       source     out_valid_o / out_stall_i value_o, base_valid_o
//   config    APB slave  psel/penable/pwrite      paddr, pwdata, prdata
//
// One item per cycle unless a stalled result holds a last item: each item is
// staged in an input register, then handled by one multiply-add (accumulator
// times radix). A last item leaving that stage loads the result register.
// Reset clears the parse state, the registers and both valid flags.
// A stalled result holds the input stage only when that stage holds a last item.
module radix_string_to_integer_parser_top #(
  parameter int unsigned MAX_DIGITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [rsip_pkg::SYM_W-1:0]        char_code_i,
  input  logic                              last_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [rsip_pkg::VALUE_W-1:0] value_o,
  output logic                              base_valid_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rsip_pkg::ADDR_W-1:0]       paddr,
  input  logic [rsip_pkg::DATA_W-1:0]       pwdata,
  output logic [rsip_pkg::DATA_W-1:0]       prdata,
  output logic                              pready
);
  import rsip_pkg::*;

  typedef enum logic [1:0] {
    PH_SPACE,
    PH_SIGN,
    PH_DIGIT,
    PH_DONE
  } phase_e;

  // Configuration registers
  logic [CNT_W-1:0]  digit_count_q;
  logic [DATA_W-1:0] symbols_low_q;
  logic [DATA_W-1:0] symbols_high_q;

  // Input stage
  logic             in_vld_q;
  logic [SYM_W-1:0] char_q;
  logic             last_q;

  // Parse state
  phase_e             phase_q, phase_d;
  logic               neg_q, neg_d;
  logic [VALUE_W-1:0] acc_q, acc_d;

  // Result register
  logic               out_vld_q;
  logic [VALUE_W-1:0] value_q, value_d;
  logic               bvalid_q;

  rsip_alpha_t alpha;
  logic        is_ws, is_sign, out_free, go;
  logic [1:0]  reg_idx;

  assign reg_idx = paddr[ADDR_W-1:3];
  assign pready  = 1'b1;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_count_q  <= '0;
      symbols_low_q  <= '0;
      symbols_high_q <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_DIGIT_COUNT:  digit_count_q  <= pwdata[CNT_W-1:0];
        REG_SYMBOLS_LOW:  symbols_low_q  <= pwdata;
        REG_SYMBOLS_HIGH: symbols_high_q <= pwdata;
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    unique case (reg_idx)
      REG_DIGIT_COUNT:  prdata = DATA_W'(digit_count_q);
      REG_SYMBOLS_LOW:  prdata = symbols_low_q;
      REG_SYMBOLS_HIGH: prdata = symbols_high_q;
      default:          prdata = '0;
    endcase
  end

  rsip_alphabet #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_alphabet (
    .digit_count_i (digit_count_q),
    .symbols_low_i (symbols_low_q),
    .symbols_high_i(symbols_high_q),
    .char_code_i   (char_q),
    .alpha_o       (alpha)
  );

  // Flow control: only a last item needs room in the result register
  assign out_free   = !out_vld_q || !out_stall_i;
  assign go         = in_vld_q && (!last_q || out_free);
  assign in_stall_o = in_vld_q && !go;

  assign is_ws   = ((char_q >= CH_TAB) && (char_q <= CH_CR)) || (char_q == CH_SPACE);
  assign is_sign = (char_q == CH_PLUS) || (char_q == CH_MINUS);

  // Next parse state for the staged character
  always_comb begin
    phase_d = phase_q;
    neg_d   = neg_q;
    acc_d   = acc_q;
    if ((phase_q == PH_SPACE) && is_ws) begin
      phase_d = PH_SPACE;
    end else if (((phase_q == PH_SPACE) || (phase_q == PH_SIGN)) && is_sign) begin
      phase_d = PH_SIGN;
      if (char_q == CH_MINUS) begin
        neg_d = !neg_q;
      end
    end else if (phase_q != PH_DONE) begin
      if (alpha.hit) begin
        phase_d = PH_DIGIT;
        acc_d   = VALUE_W'(acc_q * VALUE_W'(alpha.radix)) + VALUE_W'(alpha.digit);
      end else begin
        phase_d = PH_DONE;
      end
    end
  end

  // Signed result; zero for an invalid alphabet
  always_comb begin
    if (!alpha.ok) begin
      value_d = '0;
    end else if (neg_d) begin
      value_d = VALUE_W'(0) - acc_d;
    end else begin
      value_d = acc_d;
    end
  end

  // Input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      char_q <= char_code_i;
      last_q <= last_i;
    end
  end

  // Parse state, cleared after each last item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SPACE;
      neg_q   <= 1'b0;
      acc_q   <= '0;
    end else if (go) begin
      if (last_q) begin
        phase_q <= PH_SPACE;
        neg_q   <= 1'b0;
        acc_q   <= '0;
      end else begin
        phase_q <= phase_d;
        neg_q   <= neg_d;
        acc_q   <= acc_d;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (go && last_q) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go && last_q) begin
      value_q  <= value_d;
      bvalid_q <= alpha.ok;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign value_o      = $signed(value_q);
  assign base_valid_o = bvalid_q;

endmodule

// ===== src/rsip_alphabet.sv =====
// Alphabet decode: digit lookup of one character and alphabet validity.
// Depends on rsip_pkg.
module rsip_alphabet #(
  parameter int unsigned MAX_DIGITS = 16
) (
  input  logic [rsip_pkg::CNT_W-1:0]   digit_count_i,
  input  logic [rsip_pkg::DATA_W-1:0]  symbols_low_i,
  input  logic [rsip_pkg::DATA_W-1:0]  symbols_high_i,
  input  logic [rsip_pkg::SYM_W-1:0]   char_code_i,
  output rsip_pkg::rsip_alpha_t        alpha_o
);
  import rsip_pkg::*;

  logic [SYM_W-1:0]   sym [NUM_SYM];
  logic [CNT_W-1:0]   radix;
  logic               hit;
  logic [DIGIT_W-1:0] digit;
  logic               ok;

  // Unpack the two symbol words, eight bytes each
  always_comb begin
    for (int i = 0; i < NUM_SYM / 2; i++) begin
      sym[i]               = symbols_low_i[i*SYM_W +: SYM_W];
      sym[i + NUM_SYM / 2] = symbols_high_i[i*SYM_W +: SYM_W];
    end
  end

  assign radix = (digit_count_i > CNT_W'(MAX_DIGITS)) ? CNT_W'(MAX_DIGITS) : digit_count_i;

  // Priority lookup: the lowest matching position wins
  always_comb begin
    hit   = 1'b0;
    digit = '0;
    for (int i = MAX_DIGITS - 1; i >= 0; i--) begin
      if ((CNT_W'(i) < radix) && (sym[i] == char_code_i)) begin
        hit   = 1'b1;
        digit = DIGIT_W'(i);
      end
    end
  end

  // Validity: count in range, no NUL, no sign symbols, no duplicates
  always_comb begin
    ok = (digit_count_i >= CNT_W'(2)) && (digit_count_i <= CNT_W'(MAX_DIGITS));
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (CNT_W'(i) < digit_count_i) begin
        if ((sym[i] == CH_NUL) || (sym[i] == CH_PLUS) || (sym[i] == CH_MINUS)) begin
          ok = 1'b0;
        end
        for (int j = i + 1; j < MAX_DIGITS; j++) begin
          if ((CNT_W'(j) < digit_count_i) && (sym[j] == sym[i])) begin
            ok = 1'b0;
          end
        end
      end
    end
  end

  assign alpha_o = '{hit: hit, digit: digit, radix: radix, ok: ok};

endmodule

// ===== src/rsip_checker.sv =====
// Port-level checker for the radix string-to-integer parser, bound to the top.
// Depends on radix_string_to_integer_parser_top_macros.svh and rsip_pkg.
`include "radix_string_to_integer_parser_top_macros.svh"

module rsip_props (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                out_valid_i,
  input logic                                out_stall_i,
  input logic signed [rsip_pkg::VALUE_W-1:0] value_i,
  input logic                                base_valid_i,
  input logic                                pready_i
);
  import rsip_pkg::*;

  // A stalled result stays offered
  `RSIP_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_i && out_stall_i |=> out_valid_i)

  // A stalled result keeps its payload
  `RSIP_ASSERT(a_out_stable, clk_i, rst_ni, out_valid_i && out_stall_i |=> $stable(value_i) && $stable(base_valid_i))

  // An invalid alphabet always reports zero
  `RSIP_ASSERT(a_bad_alpha_zero, clk_i, rst_ni, out_valid_i && !base_valid_i |-> value_i == '0)

  // The register port never inserts wait states
  `RSIP_ASSERT_ALWAYS(a_pready_high, clk_i, pready_i == 1'b1)

endmodule

bind radix_string_to_integer_parser_top rsip_props u_rsip_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .value_i     (value_o),
  .base_valid_i(base_valid_o),
  .pready_i    (pready)
);

// ===== tb/rsip_checker.sv =====
`timescale 1ns / 1ps
// Checker for the radix string-to-integer parser: watches the item channels and
// the register port, predicts every parsed result and compares. Uses rsip_pkg.
module rsip_checker #(
  parameter int unsigned MAX_DIGITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic                                in_stall_i,
  input  logic [rsip_pkg::SYM_W-1:0]          char_code_i,
  input  logic                                last_i,
  input  logic                                out_valid_i,
  input  logic                                out_stall_i,
  input  logic signed [rsip_pkg::VALUE_W-1:0] value_i,
  input  logic                                base_valid_i,
  input  logic                                psel_i,
  input  logic                                penable_i,
  input  logic                                pwrite_i,
  input  logic [rsip_pkg::ADDR_W-1:0]         paddr_i,
  input  logic [rsip_pkg::DATA_W-1:0]         pwdata_i,
  input  logic                                pready_i,
  output int unsigned                         fail_count_o,
  output int unsigned                         pending_o
);
  import rsip_pkg::*;

  typedef enum logic [1:0] {SCAN_SPACE, SCAN_SIGN, SCAN_DIGIT, SCAN_DONE} scan_state_e;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      base_valid;
  } parse_result_t;

  // Register copies and parse state of the predictor
  logic [CNT_W-1:0]   cfg_count;
  logic [DATA_W-1:0]  cfg_lo;
  logic [DATA_W-1:0]  cfg_hi;
  scan_state_e        scan_state;
  logic               negative;
  logic [VALUE_W-1:0] acc;
  parse_result_t      parsed_q[$];
  int unsigned        mismatches;

  function automatic logic [SYM_W-1:0] symbol_at(input int unsigned idx);
    logic [DATA_W-1:0] word;
    word = (idx < 8) ? cfg_lo : cfg_hi;
    return word[8*(idx%8) +: 8];
  endfunction

  // Symbol count clamped to the maximum alphabet size
  function automatic int unsigned radix_in_use();
    return (cfg_count > MAX_DIGITS) ? MAX_DIGITS : cfg_count;
  endfunction

  // Lowest position of a character in the alphabet, -1 when absent
  function automatic int symbol_position(input logic [SYM_W-1:0] ch);
    int unsigned i;
    for (i = 0; i < radix_in_use(); i++) begin
      if (symbol_at(i) == ch) begin
        return i;
      end
    end
    return -1;
  endfunction

  function automatic logic alphabet_legal();
    int unsigned i;
    int unsigned j;
    logic [SYM_W-1:0] s;
    if (cfg_count < 2 || cfg_count > MAX_DIGITS) begin
      return 1'b0;
    end
    for (i = 0; i < cfg_count; i++) begin
      s = symbol_at(i);
      if (s == CH_NUL || s == CH_PLUS || s == CH_MINUS) begin
        return 1'b0;
      end
      for (j = i + 1; j < cfg_count; j++) begin
        if (symbol_at(j) == s) begin
          return 1'b0;
        end
      end
    end
    return 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    parse_result_t    want;
    logic [SYM_W-1:0] ch;
    logic             blank;
    logic             sign_ch;
    int               pos;
    if (!rst_ni) begin
      cfg_count  = '0;
      cfg_lo     = '0;
      cfg_hi     = '0;
      scan_state = SCAN_SPACE;
      negative   = 1'b0;
      acc        = '0;
      mismatches = 0;
      parsed_q.delete();
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      // Result side: compare against the oldest prediction
      if (out_valid_i && !out_stall_i) begin
        if (parsed_q.size() == 0) begin
          $display("%0t: result with none expected: value=%0d base_valid=%0b",
                   $time, value_i, base_valid_i);
          mismatches++;
        end else begin
          want = parsed_q.pop_front();
          if (value_i !== want.value) begin
            $display("%0t: value mismatch: expected %0d actual %0d",
                     $time, want.value, value_i);
            mismatches++;
          end
          if (base_valid_i !== want.base_valid) begin
            $display("%0t: base_valid mismatch: expected %0b actual %0b",
                     $time, want.base_valid, base_valid_i);
            mismatches++;
          end
        end
      end

      // Register writes
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[ADDR_W-1:3])
          REG_DIGIT_COUNT:  cfg_count = pwdata_i[CNT_W-1:0];
          REG_SYMBOLS_LOW:  cfg_lo = pwdata_i;
          REG_SYMBOLS_HIGH: cfg_hi = pwdata_i;
          default: begin
          end
        endcase
      end

      // Input side: advance the parse by one character
      if (in_valid_i && !in_stall_i) begin
        ch      = char_code_i;
        blank   = (ch >= CH_TAB && ch <= CH_CR) || ch == CH_SPACE;
        sign_ch = ch == CH_PLUS || ch == CH_MINUS;
        if (scan_state == SCAN_SPACE && blank) begin
          // leading whitespace wins over any alphabet match
        end else if ((scan_state == SCAN_SPACE || scan_state == SCAN_SIGN) && sign_ch) begin
          scan_state = SCAN_SIGN;
          if (ch == CH_MINUS) begin
            negative = ~negative;
          end
        end else if (scan_state != SCAN_DONE) begin
          pos = symbol_position(ch);
          if (pos >= 0) begin
            scan_state = SCAN_DIGIT;
            acc = acc * VALUE_W'(radix_in_use()) + VALUE_W'(pos);
          end else begin
            scan_state = SCAN_DONE;
          end
        end
        if (last_i) begin
          want.base_valid = alphabet_legal();
          want.value      = want.base_valid ? (negative ? -acc : acc) : '0;
          parsed_q.push_back(want);
          scan_state = SCAN_SPACE;
          negative   = 1'b0;
          acc        = '0;
        end
      end

      pending_o    <= parsed_q.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Testbench top for radix_string_to_integer_parser_top: drives strings and
// register settings, gives the verdict. Uses rsip_pkg and rsip_checker.
module tb;
  import rsip_pkg::*;

  localparam int unsigned MAX_DIGITS      = 16;
  localparam int unsigned PHASES          = 14;
  localparam int unsigned ITEMS_PER_PHASE = 125;
  localparam int unsigned DRAIN_CYCLES    = 4;

  logic                      clk_i      = 1'b0;
  logic                      rst_ni     = 1'b0;
  logic                      in_valid   = 1'b0;
  logic [SYM_W-1:0]          char_code  = '0;
  logic                      last_flag  = 1'b0;
  logic                      out_stall  = 1'b0;
  logic                      psel       = 1'b0;
  logic                      penable    = 1'b0;
  logic                      pwrite     = 1'b0;
  logic [ADDR_W-1:0]         paddr      = '0;
  logic [DATA_W-1:0]         pwdata     = '0;
  logic                      in_stall;
  logic                      out_valid;
  logic signed [VALUE_W-1:0] value;
  logic                      base_valid;
  logic [DATA_W-1:0]         prdata;
  logic                      pready;
  int unsigned               fail_count;
  int unsigned               results_pending;

  int unsigned               send_idle_pct  = 0;
  int unsigned               recv_stall_pct = 0;
  int unsigned               item_count     = 0;
  logic [CNT_W-1:0]          alpha_count    = '0;
  logic [DATA_W-1:0]         alpha_lo       = '0;
  logic [DATA_W-1:0]         alpha_hi       = '0;

  radix_string_to_integer_parser_top #(
    .MAX_DIGITS(MAX_DIGITS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .char_code_i (char_code),
    .last_i      (last_flag),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .value_o     (value),
    .base_valid_o(base_valid),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  rsip_checker #(
    .MAX_DIGITS(MAX_DIGITS)
  ) checker_u (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .char_code_i (char_code),
    .last_i      (last_flag),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .value_i     (value),
    .base_valid_i(base_valid),
    .psel_i      (psel),
    .penable_i   (penable),
    .pwrite_i    (pwrite),
    .paddr_i     (paddr),
    .pwdata_i    (pwdata),
    .pready_i    (pready),
    .fail_count_o(fail_count),
    .pending_o   (results_pending)
  );

  always #4 clk_i = ~clk_i;

  // Result-side backpressure
  always @(posedge clk_i) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Watchdog
  initial begin
    #4_000_000;
    $display("radix_string_to_integer_parser_top test failed");
    $finish;
  end

  // Symbol i of a word holds character i of the string
  function automatic logic [DATA_W-1:0] pack_symbols(input string s);
    logic [DATA_W-1:0] word;
    int i;
    word = '0;
    for (i = 0; i < s.len() && i < 8; i++) begin
      word[8*i +: 8] = s[i];
    end
    return word;
  endfunction

  // One character from the active alphabet, random byte if it is empty
  function automatic logic [SYM_W-1:0] random_symbol();
    int unsigned n;
    int unsigned k;
    n = (alpha_count > MAX_DIGITS) ? MAX_DIGITS : alpha_count;
    if (n == 0) begin
      return SYM_W'($urandom);
    end
    k = $urandom_range(n - 1, 0);
    return (k < 8) ? alpha_lo[8*k +: 8] : alpha_hi[8*(k-8) +: 8];
  endfunction

  task automatic reg_write(input logic [1:0] idx, input logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_alphabet(input logic [CNT_W-1:0] count,
                              input logic [DATA_W-1:0] lo,
                              input logic [DATA_W-1:0] hi);
    reg_write(REG_DIGIT_COUNT, DATA_W'(count));
    reg_write(REG_SYMBOLS_LOW, lo);
    reg_write(REG_SYMBOLS_HIGH, hi);
    alpha_count = count;
    alpha_lo    = lo;
    alpha_hi    = hi;
  endtask

  // Sixteen distinct legal symbols; whitespace may land among them
  task automatic random_alphabet(input int unsigned count);
    logic [SYM_W-1:0]  pool [NUM_SYM];
    logic [SYM_W-1:0]  b;
    logic              clash;
    logic [DATA_W-1:0] lo;
    logic [DATA_W-1:0] hi;
    int unsigned       i;
    int unsigned       j;
    for (i = 0; i < NUM_SYM; i++) begin
      do begin
        b = SYM_W'($urandom_range(255, 1));
        clash = (b == CH_PLUS) || (b == CH_MINUS);
        for (j = 0; j < i; j++) begin
          if (pool[j] == b) begin
            clash = 1'b1;
          end
        end
      end while (clash);
      pool[i] = b;
    end
    for (i = 0; i < 8; i++) begin
      lo[8*i +: 8] = pool[i];
      hi[8*i +: 8] = pool[i+8];
    end
    set_alphabet(CNT_W'(count), lo, hi);
  endtask

  // One item, with random idle cycles ahead of it
  task automatic send_char(input logic [SYM_W-1:0] ch, input logic lst);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    char_code <= ch;
    last_flag <= lst;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    item_count++;
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) begin
      send_char(s[i], i == s.len() - 1);
    end
  endtask

  // Hold off the sender until every result is out and the pipe is empty
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (results_pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin : stimulus
    logic [SYM_W-1:0] text_q[$];
    int unsigned      p;
    int unsigned      n;
    int unsigned      k;
    int unsigned      phase_start;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (p = 0; p < PHASES; p++) begin
      drain();

      // Alphabet for this phase
      case (p)
        0:  set_alphabet(5'd10, pack_symbols("01234567"), pack_symbols("89"));
        1:  set_alphabet(5'd2, pack_symbols("01xyzuvw"), pack_symbols("QRSTUVWX"));
        2:  set_alphabet(5'd16, pack_symbols("01234567"), pack_symbols("89abcdef"));
        3:  set_alphabet(5'd16, '1, '1);
        4:  set_alphabet(5'd0, '0, '0);
        5:  set_alphabet(5'd31, pack_symbols("01234567"), pack_symbols("89ABCDEF"));
        6:  set_alphabet(5'd1, pack_symbols("a"), '0);
        7:  set_alphabet(5'd12, pack_symbols(" \tabcdef"), pack_symbols("ghij"));
        8:  set_alphabet(5'd8, pack_symbols("abc+efgh"), pack_symbols("ijklmnop"));
        9:  set_alphabet(5'd6, pack_symbols("abcde"), pack_symbols("ijkl"));
        10: set_alphabet(5'd10, pack_symbols("01234562"), pack_symbols("89"));
        11: random_alphabet($urandom_range(16, 2));
        12: set_alphabet(CNT_W'($urandom), {$urandom, $urandom}, {$urandom, $urandom});
        default: random_alphabet(NUM_SYM);
      endcase

      // Idle pattern for this phase
      case (p % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 84;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 84;
        end
        default: begin
          send_idle_pct  = 24;
          recv_stall_pct = 24;
        end
      endcase

      phase_start = item_count;

      // Directed strings on the decimal alphabet
      if (p == 0) begin
        send_text("\t -+-7x9");     // blanks, sign run, digit, stop, ignored tail
        send_char(CH_CR, 1'b1);     // whitespace only
        send_char(CH_MINUS, 1'b1);  // sign only
        send_char(CH_NUL, 1'b0);    // zero byte ends the number
        send_text("5");
        send_char(8'hFF, 1'b1);     // top code, not a symbol
        send_text("4294967301");    // wraps past 32 bits
        send_text("5-");            // sign after digits ends the number
      end

      // Random strings: mostly well formed, some noise
      while (item_count - phase_start < ITEMS_PER_PHASE) begin
        text_q.delete();
        if ($urandom_range(99) < 75) begin
          repeat ($urandom_range(2)) begin
            k = $urandom_range(5);
            text_q.push_back((k == 5) ? CH_SPACE : CH_TAB + SYM_W'(k));
          end
          repeat ($urandom_range(3)) begin
            text_q.push_back($urandom_range(1) ? CH_MINUS : CH_PLUS);
          end
          n = ($urandom_range(99) < 80) ? $urandom_range(4, 1) : $urandom_range(12, 5);
          repeat (n) begin
            text_q.push_back(random_symbol());
          end
          repeat ($urandom_range(2)) begin
            text_q.push_back(SYM_W'($urandom));
          end
        end else begin
          repeat ($urandom_range(6, 1)) begin
            k = $urandom_range(3);
            case (k)
              2:       text_q.push_back(random_symbol());
              3:       text_q.push_back($urandom_range(1) ? CH_MINUS : CH_SPACE);
              default: text_q.push_back(SYM_W'($urandom));
            endcase
          end
        end
        for (k = 0; k < text_q.size(); k++) begin
          send_char(text_q[k], k == text_q.size() - 1);
        end
      end
    end

    drain();
    if (fail_count == 0 && results_pending == 0) begin
      $display("radix_string_to_integer_parser_top test passed");
    end else begin
      $display("radix_string_to_integer_parser_top test failed");
    end
    $finish;
  end

endmodule
